/* src/fdt_pkg.sv */
`timescale 1ns / 1ps

package fdt_pkg;

  // payload field widths
  localparam int KIND_W    = 3;
  localparam int CHAN_W    = 5;
  localparam int READ_W    = 2;
  localparam int LEVEL_W   = 16;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 16;

  // word kinds
  localparam logic [KIND_W-1:0] KIND_SAMPLE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REGISTER = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESET    = 3'd4;

  // raw readings
  localparam logic [READ_W-1:0] RD_NORMAL = 2'd0;
  localparam logic [READ_W-1:0] RD_FAULT  = 2'd1;

  // monitor phases, also the status code
  localparam logic [STATUS_W-1:0] PH_INIT   = 2'd0;
  localparam logic [STATUS_W-1:0] PH_NORMAL = 2'd1;
  localparam logic [STATUS_W-1:0] PH_FAULT  = 2'd2;

  // counting modes
  localparam logic MODE_CONT  = 1'b0;
  localparam logic MODE_ACCUM = 1'b1;

endpackage

/* src/fdt_if.sv */
`timescale 1ns / 1ps

interface fdt_req_if;
  logic                          valid;
  logic                          ready;
  logic [fdt_pkg::KIND_W-1:0]    kind;
  logic [fdt_pkg::CHAN_W-1:0]    channel;
  logic [fdt_pkg::READ_W-1:0]    raw_reading;
  logic                          mode;
  logic [fdt_pkg::LEVEL_W-1:0]   trigger_level;
  logic [fdt_pkg::LEVEL_W-1:0]   recover_level;
  logic [fdt_pkg::LEVEL_W-1:0]   latch_limit;

  modport source (
    output valid, kind, channel, raw_reading, mode, trigger_level, recover_level,
           latch_limit,
    input  ready
  );
  modport sink (
    input  valid, kind, channel, raw_reading, mode, trigger_level, recover_level,
           latch_limit,
    output ready
  );
endinterface

interface fdt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [fdt_pkg::CHAN_W-1:0]     slot;
  logic                           ok;
  logic [fdt_pkg::STATUS_W-1:0]   status;
  logic                           is_latched;
  logic [fdt_pkg::ENTRIES_W-1:0]  entries;

  modport source (
    output valid, slot, ok, status, is_latched, entries,
    input  ready
  );
  modport sink (
    input  valid, slot, ok, status, is_latched, entries,
    output ready
  );
endinterface

/* src/fdt_ram.sv */
`timescale 1ns / 1ps

module fdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/fault_debounce_table.sv */
`timescale 1ns / 1ps
// path: an accepted word passes the stage 1, stage 2 and result registers in order
// throughput: one word per cycle; the pipeline only halts while a result waits
// on the response side, and the input side stalls along with it
// reset: rst clears the slot-in-use flags and all pipeline valids; the table
// memory is not swept, since a slot is always written when it is registered

module fault_debounce_table #(
  parameter int CHANNELS   = 32,
  parameter int COUNT_BITS = 16
) (
  input logic            clk,
  input logic            rst,
  fdt_req_if.sink        req,
  fdt_rsp_if.source      rsp
);

  import fdt_pkg::*;

  localparam int SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // compare width covering both the counters and the 16-bit levels
  localparam int CMP_W  = (COUNT_BITS > LEVEL_W) ? COUNT_BITS : LEVEL_W;

  // one table entry: settings, then phase, latch and the counters
  typedef struct packed {
    logic                  mode;
    logic [LEVEL_W-1:0]    trig;
    logic [LEVEL_W-1:0]    rec;
    logic [LEVEL_W-1:0]    latch;
    logic [STATUS_W-1:0]   phase;
    logic                  locked;
    logic [COUNT_BITS-1:0] fr;
    logic [COUNT_BITS-1:0] nr;
    logic [COUNT_BITS-1:0] acc;
    logic [COUNT_BITS-1:0] ec;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic [CMP_W-1:0] cwide(input logic [COUNT_BITS-1:0] v);
    return CMP_W'(v);
  endfunction

  function automatic logic [CMP_W-1:0] lwide(input logic [LEVEL_W-1:0] v);
    return CMP_W'(v);
  endfunction

  // whole pipeline moves together; it halts only when the result register is full and not taken
  logic adv;
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // slot-in-use flags, one per slot, cleared by reset
  logic [CHANNELS-1:0] in_use;
  logic [CHANNELS-1:0] in_use_next;

  // ---------------------------------------------------------------------------
  // stage 1: input register, slot selection, in-use update, table read
  // ---------------------------------------------------------------------------
  logic                s1_valid;
  logic [KIND_W-1:0]   s1_kind;
  logic [CHAN_W-1:0]   s1_channel;
  logic [READ_W-1:0]   s1_raw;
  logic                s1_mode;
  logic [LEVEL_W-1:0]  s1_trig;
  logic [LEVEL_W-1:0]  s1_rec;
  logic [LEVEL_W-1:0]  s1_latch;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && req.valid) begin
      s1_kind    <= req.kind;
      s1_channel <= req.channel;
      s1_raw     <= req.raw_reading;
      s1_mode    <= req.mode;
      s1_trig    <= req.trigger_level;
      s1_rec     <= req.recover_level;
      s1_latch   <= req.latch_limit;
    end
  end

  logic              s1_is_reg;
  logic              s1_ch_ok;
  logic [SLOT_W-1:0] s1_ch_idx;
  logic              s1_free_found;
  logic [SLOT_W-1:0] s1_free_idx;
  logic [SLOT_W-1:0] s1_tgt;
  logic              s1_tgt_ok;
  logic              s1_use_before;
  logic              s1_use_after;
  logic [CHAN_W-1:0] s1_slot;

  // lowest free slot: scan from the top so the lowest index wins
  always_comb begin
    s1_free_found = 1'b0;
    s1_free_idx   = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        s1_free_found = 1'b1;
        s1_free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    s1_is_reg     = (s1_kind == KIND_REGISTER);
    s1_ch_ok      = (int'(s1_channel) < CHANNELS);
    s1_ch_idx     = SLOT_W'(s1_channel);
    s1_tgt        = s1_is_reg ? s1_free_idx : s1_ch_idx;
    s1_tgt_ok     = s1_is_reg ? s1_free_found : s1_ch_ok;
    s1_use_before = s1_tgt_ok && in_use[s1_tgt];
    priority if (s1_is_reg) begin
      s1_use_after = s1_tgt_ok;
    end else if (s1_kind == KIND_RELEASE) begin
      s1_use_after = 1'b0;
    end else begin
      s1_use_after = s1_use_before;
    end
    // a full table reports slot zero
    if (s1_is_reg) begin
      s1_slot = s1_free_found ? CHAN_W'(s1_free_idx) : '0;
    end else begin
      s1_slot = s1_channel;
    end
  end

  // in-use changes never depend on the counters, so they commit here
  always_comb begin
    in_use_next = in_use;
    if (adv && s1_valid && s1_tgt_ok) begin
      if (s1_is_reg) begin
        in_use_next[s1_tgt] = 1'b1;
      end else if (s1_kind == KIND_RELEASE) begin
        in_use_next[s1_tgt] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else begin
      in_use <= in_use_next;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: entry arrives from the table, update and write back
  // ---------------------------------------------------------------------------
  logic                s2_valid;
  logic [KIND_W-1:0]   s2_kind;
  logic [READ_W-1:0]   s2_raw;
  logic                s2_mode;
  logic [LEVEL_W-1:0]  s2_trig;
  logic [LEVEL_W-1:0]  s2_rec;
  logic [LEVEL_W-1:0]  s2_latch;
  logic [SLOT_W-1:0]   s2_tgt;
  logic                s2_tgt_ok;
  logic                s2_use_before;
  logic                s2_use_after;
  logic [CHAN_W-1:0]   s2_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      s2_kind       <= s1_kind;
      s2_raw        <= s1_raw;
      s2_mode       <= s1_mode;
      s2_trig       <= s1_trig;
      s2_rec        <= s1_rec;
      s2_latch      <= s1_latch;
      s2_tgt        <= s1_tgt;
      s2_tgt_ok     <= s1_tgt_ok;
      s2_use_before <= s1_use_before;
      s2_use_after  <= s1_use_after;
      s2_slot       <= s1_slot;
    end
  end

  logic               wr_en;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;

  fdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s2_tgt),
    .wdata (wr_data),
    .re    (adv),
    .raddr (s1_tgt),
    .rdata (rd_data)
  );

  // back-to-back words on one slot: the table read misses the write that
  // lands on the same edge, so that write is kept and used instead
  logic               byp_hit;
  logic [ENTRY_W-1:0] byp_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else if (adv) begin
      byp_hit <= wr_en && s1_valid && s1_tgt_ok && (s1_tgt == s2_tgt);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byp_data <= wr_data;
    end
  end

  entry_t cur;
  entry_t nxt;
  assign cur = entry_t'(byp_hit ? byp_data : rd_data);

  logic                  is_fault;
  logic                  do_sample;
  logic                  enter;
  logic [COUNT_BITS-1:0] fr1;
  logic [COUNT_BITS-1:0] nr1;
  logic [COUNT_BITS-1:0] acc1;
  logic [COUNT_BITS-1:0] ec1;
  logic                  fr_trip;
  logic                  nr_trip;
  logic                  acc_trip;
  logic                  acc_low;
  logic                  latch_hit;

  // candidate counter values for a sample
  always_comb begin
    is_fault  = (s2_raw == RD_FAULT);
    do_sample = (s2_kind == KIND_SAMPLE) && s2_use_before && !cur.locked &&
                ((s2_raw == RD_NORMAL) || (s2_raw == RD_FAULT));
    fr1 = is_fault ? sat_inc(cur.fr) : '0;
    nr1 = is_fault ? '0 : sat_inc(cur.nr);
    if (is_fault) begin
      acc1 = (cwide(cur.acc) < lwide(cur.trig)) ? sat_inc(cur.acc) : cur.acc;
    end else begin
      acc1 = (cur.acc != '0) ? cur.acc - COUNT_BITS'(1) : cur.acc;
    end
    ec1       = sat_inc(cur.ec);
    fr_trip   = cwide(fr1)  >= lwide(cur.trig);
    nr_trip   = cwide(nr1)  >= lwide(cur.rec);
    acc_trip  = cwide(acc1) >= lwide(cur.trig);
    acc_low   = cwide(acc1) <  lwide(cur.rec);
    latch_hit = (cur.latch != '0) && (cwide(ec1) >= lwide(cur.latch));
  end

  // next entry for every kind of word
  always_comb begin
    nxt   = cur;
    enter = 1'b0;
    unique case (s2_kind)
      KIND_SAMPLE: begin
        if (do_sample) begin
          if (cur.mode == MODE_CONT) begin
            nxt.fr = fr1;
            nxt.nr = nr1;
            if (cur.phase != PH_FAULT && fr_trip) begin
              enter  = 1'b1;
              nxt.fr = '0;
            end else if (nr_trip) begin
              nxt.phase = PH_NORMAL;
              nxt.nr    = '0;
            end
          end else begin
            nxt.acc = acc1;
            if (cur.phase != PH_FAULT) begin
              if (acc_trip) begin
                enter = 1'b1;
              end else if (cur.phase == PH_INIT && !is_fault) begin
                nxt.phase = PH_NORMAL;
              end
            end else if (acc_low) begin
              nxt.phase = PH_NORMAL;
            end
          end
          if (enter) begin
            nxt.phase = PH_FAULT;
            nxt.ec    = ec1;
            if (latch_hit) begin
              nxt.locked = 1'b1;
            end
          end
        end
      end
      KIND_REGISTER: begin
        nxt.mode   = s2_mode;
        nxt.trig   = s2_trig;
        nxt.rec    = s2_rec;
        nxt.latch  = s2_latch;
        nxt.phase  = PH_INIT;
        nxt.locked = 1'b0;
        nxt.fr     = '0;
        nxt.nr     = '0;
        nxt.acc    = '0;
        nxt.ec     = '0;
      end
      KIND_CLEAR, KIND_RESET: begin
        // clear latch acts only on a latched slot, reset on any slot in use
        if (s2_use_before && (cur.locked || s2_kind == KIND_RESET)) begin
          nxt.phase  = PH_INIT;
          nxt.locked = 1'b0;
          nxt.fr     = '0;
          nxt.nr     = '0;
          nxt.acc    = '0;
          nxt.ec     = '0;
        end
      end
      default: begin
        // release and unknown kinds leave the entry as it is
      end
    endcase
  end

  assign wr_en   = adv && s2_valid && s2_tgt_ok;
  assign wr_data = ENTRY_W'(nxt);

  // entry count clipped to the 16-bit result field
  logic [ENTRIES_W-1:0] ent_sat;
  always_comb begin
    if (cwide(nxt.ec) > CMP_W'({ENTRIES_W{1'b1}})) begin
      ent_sat = {ENTRIES_W{1'b1}};
    end else begin
      ent_sat = ENTRIES_W'(cwide(nxt.ec));
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic                 out_valid;
  logic [CHAN_W-1:0]    out_slot;
  logic                 out_ok;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_latched;
  logic [ENTRIES_W-1:0] out_entries;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      out_slot    <= s2_slot;
      out_ok      <= s2_use_after;
      out_status  <= s2_use_after ? nxt.phase : PH_INIT;
      out_latched <= s2_use_after && nxt.locked;
      out_entries <= s2_use_after ? ent_sat : '0;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.slot       = out_slot;
  assign rsp.ok         = out_ok;
  assign rsp.status     = out_status;
  assign rsp.is_latched = out_latched;
  assign rsp.entries    = out_entries;

`ifndef ASSERT_OFF
  // in-use flags move only when a word leaves stage 1
  a_in_use_hold: assert property (@(posedge clk) disable iff (rst)
    !(adv && s1_valid) |=> $stable(in_use))
    else $error("in-use flags changed without a word in stage 1");

  // a successful registration takes exactly one more slot
  a_reg_one_slot: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_valid && s1_is_reg && s1_free_found) |=>
      ($countones(in_use) == $past($countones(in_use)) + 1))
    else $error("registration did not claim exactly one slot");

  // forwarded entry only ever feeds a live stage 2 word
  a_byp_live: assert property (@(posedge clk) disable iff (rst)
    byp_hit |-> s2_valid)
    else $error("forwarded entry without a word in stage 2");

  // an unused or invalid slot reports a blank state
  a_blank_unused: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ok) |->
      (rsp.status == PH_INIT && !rsp.is_latched && rsp.entries == '0))
    else $error("unused slot reported non-blank state");

  // a latched monitor stays in fault until cleared
  a_latch_fault: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.is_latched) |-> (rsp.status == PH_FAULT))
    else $error("latched monitor reported outside fault");
`endif

endmodule

/* tb/fault_debounce_table_tb.sv */
`timescale 1ns / 1ps

module fault_debounce_table_tb;
  import fdt_pkg::*;

  localparam int CHANNELS = 32;
  localparam int CLK_HALF = 5;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = '1;
  localparam logic [KIND_W-1:0]  KIND_TOP   = '1;    // highest of the undefined kinds
  localparam logic [READ_W-1:0]  RD_INVALID = 2'd2;
  localparam logic [READ_W-1:0]  RD_SPARE   = 2'd3;  // unused code, acts as invalid

  // one request word as the testbench sees it
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CHAN_W-1:0]  channel;
    logic [READ_W-1:0]  raw_reading;
    logic               mode;
    logic [LEVEL_W-1:0] trigger_level;
    logic [LEVEL_W-1:0] recover_level;
    logic [LEVEL_W-1:0] latch_limit;
  } monitor_cmd_t;

  // one response word
  typedef struct packed {
    logic [CHAN_W-1:0]    slot;
    logic                 ok;
    logic [STATUS_W-1:0]  status;
    logic                 is_latched;
    logic [ENTRIES_W-1:0] entries;
  } monitor_report_t;

  logic clk;
  logic rst;

  fdt_req_if req();
  fdt_rsp_if rsp();

  fault_debounce_table uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // shadow copy of the monitor table
  logic                 mon_used       [CHANNELS];
  logic                 mon_locked     [CHANNELS];
  logic [STATUS_W-1:0]  mon_phase      [CHANNELS];
  logic [LEVEL_W-1:0]   fault_run_len  [CHANNELS];
  logic [LEVEL_W-1:0]   normal_run_len [CHANNELS];
  logic [LEVEL_W-1:0]   up_down_cnt    [CHANNELS];
  logic [ENTRIES_W-1:0] fault_entries  [CHANNELS];
  logic                 mon_mode       [CHANNELS];
  logic [LEVEL_W-1:0]   mon_trigger    [CHANNELS];
  logic [LEVEL_W-1:0]   mon_recover    [CHANNELS];
  logic [LEVEL_W-1:0]   mon_latch      [CHANNELS];

  // responses still owed by the block, oldest first
  monitor_report_t reports_due[$];
  monitor_report_t oldest_report;

  bit idle_on    = 1'b1;  // random gaps and stalls when set
  int ready_hold = 0;     // cycles the sink keeps ready low before the next word
  int errors     = 0;

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // all counters saturate at 16 bits
  function automatic logic [LEVEL_W-1:0] count_up(input logic [LEVEL_W-1:0] v);
    return (v == LEVEL_MAX) ? v : v + 1'b1;
  endfunction

  function automatic void restart_monitor(input int c);
    mon_phase[c]      = PH_INIT;
    fault_run_len[c]  = '0;
    normal_run_len[c] = '0;
    up_down_cnt[c]    = '0;
    fault_entries[c]  = '0;
    mon_locked[c]     = 1'b0;
  endfunction

  // latch limit 0 means the monitor never latches
  function automatic void enter_fault(input int c);
    mon_phase[c]     = PH_FAULT;
    fault_entries[c] = count_up(fault_entries[c]);
    if (mon_latch[c] != '0 && fault_entries[c] >= mon_latch[c]) mon_locked[c] = 1'b1;
  endfunction

  // applies one accepted word to the shadow table and returns the response it owes;
  // the channel field is 5 bits wide, so it can never fall outside the table
  function automatic monitor_report_t predict_report(input monitor_cmd_t cmd);
    monitor_report_t rep;
    int c;
    int free_slot;
    logic is_fault;
    rep      = '0;
    rep.slot = cmd.channel;
    c        = cmd.channel;
    is_fault = (cmd.raw_reading == RD_FAULT);
    case (cmd.kind)
      KIND_REGISTER: begin
        free_slot = -1;
        for (int i = CHANNELS - 1; i >= 0; i--) if (!mon_used[i]) free_slot = i;
        // table full: nothing changes and slot reads 0
        if (free_slot < 0) begin
          rep.slot = '0;
          return rep;
        end
        c = free_slot;
        restart_monitor(c);
        mon_mode[c]    = cmd.mode;
        mon_trigger[c] = cmd.trigger_level;
        mon_recover[c] = cmd.recover_level;
        mon_latch[c]   = cmd.latch_limit;
        mon_used[c]    = 1'b1;
        rep.slot       = CHAN_W'(c);
      end
      KIND_SAMPLE: begin
        // unused or latched monitors and invalid readings leave the table alone
        if (mon_used[c] && !mon_locked[c] && cmd.raw_reading <= RD_FAULT) begin
          if (mon_mode[c] == MODE_CONT) begin
            // runs of equal readings
            if (is_fault) begin
              fault_run_len[c]  = count_up(fault_run_len[c]);
              normal_run_len[c] = '0;
            end else begin
              normal_run_len[c] = count_up(normal_run_len[c]);
              fault_run_len[c]  = '0;
            end
            if (mon_phase[c] != PH_FAULT && fault_run_len[c] >= mon_trigger[c]) begin
              enter_fault(c);
              fault_run_len[c] = '0;
            end else if (normal_run_len[c] >= mon_recover[c]) begin
              mon_phase[c]      = PH_NORMAL;
              normal_run_len[c] = '0;
            end
          end else begin
            // up/down count, capped at the trigger level
            if (is_fault) begin
              if (up_down_cnt[c] < mon_trigger[c]) up_down_cnt[c] = count_up(up_down_cnt[c]);
            end else if (up_down_cnt[c] != '0) begin
              up_down_cnt[c] = up_down_cnt[c] - 1'b1;
            end
            if (mon_phase[c] == PH_FAULT) begin
              if (up_down_cnt[c] < mon_recover[c]) mon_phase[c] = PH_NORMAL;
            end else if (up_down_cnt[c] >= mon_trigger[c]) begin
              enter_fault(c);
            end else if (mon_phase[c] == PH_INIT && !is_fault) begin
              mon_phase[c] = PH_NORMAL;
            end
          end
        end
      end
      KIND_RELEASE: mon_used[c] = 1'b0;
      KIND_CLEAR:   if (mon_used[c] && mon_locked[c]) restart_monitor(c);
      KIND_RESET:   if (mon_used[c]) restart_monitor(c);
      default: ;    // undefined kinds leave the table alone and only report on the channel
    endcase
    if (mon_used[c]) begin
      rep.ok         = 1'b1;
      rep.status     = mon_phase[c];
      rep.is_latched = mon_locked[c];
      rep.entries    = fault_entries[c];
    end
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // word builders: fields the kind ignores get random content
  // ---------------------------------------------------------------------------

  function automatic monitor_cmd_t cmd_op(input logic [KIND_W-1:0] kind, input int ch);
    monitor_cmd_t cmd;
    cmd.kind          = kind;
    cmd.channel       = CHAN_W'(ch);
    cmd.raw_reading   = READ_W'($urandom);
    cmd.mode          = 1'($urandom_range(0, 1));
    cmd.trigger_level = LEVEL_W'($urandom);
    cmd.recover_level = LEVEL_W'($urandom);
    cmd.latch_limit   = LEVEL_W'($urandom);
    return cmd;
  endfunction

  function automatic monitor_cmd_t cmd_sample(input int ch, input logic [READ_W-1:0] raw);
    monitor_cmd_t cmd;
    cmd             = cmd_op(KIND_SAMPLE, ch);
    cmd.raw_reading = raw;
    return cmd;
  endfunction

  function automatic monitor_cmd_t cmd_register(input logic mode,
                                                input logic [LEVEL_W-1:0] trig,
                                                input logic [LEVEL_W-1:0] rec,
                                                input logic [LEVEL_W-1:0] latch);
    monitor_cmd_t cmd;
    cmd               = cmd_op(KIND_REGISTER, $urandom_range(0, CHANNELS - 1));
    cmd.mode          = mode;
    cmd.trigger_level = trig;
    cmd.recover_level = rec;
    cmd.latch_limit   = latch;
    return cmd;
  endfunction

  // mostly small levels so monitors move quickly, now and then any 16-bit value
  function automatic logic [LEVEL_W-1:0] pick_level(input int hi);
    if ($urandom_range(0, 7) == 0) return LEVEL_W'($urandom);
    return LEVEL_W'($urandom_range(0, hi));
  endfunction

  function automatic monitor_cmd_t random_register();
    return cmd_register(1'($urandom_range(0, 1)), pick_level(6), pick_level(6), pick_level(4));
  endfunction

  // ---------------------------------------------------------------------------
  // request side: payload changes at the falling edge, acceptance seen at the rising edge
  // ---------------------------------------------------------------------------

  task automatic send_word(input monitor_cmd_t cmd, output monitor_report_t rep);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.kind          <= cmd.kind;
    req.channel       <= cmd.channel;
    req.raw_reading   <= cmd.raw_reading;
    req.mode          <= cmd.mode;
    req.trigger_level <= cmd.trigger_level;
    req.recover_level <= cmd.recover_level;
    req.latch_limit   <= cmd.latch_limit;
    req.valid         <= 1'b1;
    do @(posedge clk); while (!req.ready);
    // the response trails acceptance by the stage 2 and result registers, so queuing here is safe
    rep = predict_report(cmd);
    reports_due.push_back(rep);
  endtask

  // ---------------------------------------------------------------------------
  // response side
  // ---------------------------------------------------------------------------

  // ready stays high unless a stall was drawn after the last word
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      rsp.ready <= 1'b0;
      ready_hold--;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (reports_due.size() == 0) begin
        errors++;
        $display("%0t: word with none expected, actual slot %0d ok %0d status %0d",
                 $time, rsp.slot, rsp.ok, rsp.status);
      end else begin
        oldest_report = reports_due.pop_front();
        check_field("slot", oldest_report.slot, rsp.slot);
        check_field("ok", oldest_report.ok, rsp.ok);
        check_field("status", oldest_report.status, rsp.status);
        check_field("is_latched", oldest_report.is_latched, rsp.is_latched);
        check_field("entries", oldest_report.entries, rsp.entries);
      end
      ready_hold = idle_on ? $urandom_range(0, 7) : 0;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked words on an empty table: slots 0, 1 and 2 are handed out in order
  task automatic test_directed();
    monitor_report_t rep;
    // operations on a slot nobody registered
    send_word(cmd_sample(5, RD_FAULT), rep);
    send_word(cmd_op(KIND_RESET, 3), rep);
    send_word(cmd_op(KIND_CLEAR, 3), rep);
    // continuous monitor that latches on its second fault entry
    send_word(cmd_register(MODE_CONT, 16'd2, 16'd1, 16'd2), rep);
    send_word(cmd_sample(0, RD_INVALID), rep);
    send_word(cmd_sample(0, RD_SPARE), rep);
    repeat (2) send_word(cmd_sample(0, RD_FAULT), rep);
    send_word(cmd_sample(0, RD_NORMAL), rep);
    repeat (2) send_word(cmd_sample(0, RD_FAULT), rep);
    // latched: the sample is ignored until the latch is cleared
    send_word(cmd_sample(0, RD_NORMAL), rep);
    send_word(cmd_op(KIND_CLEAR, 0), rep);
    // undefined kinds, lowest and highest
    send_word(cmd_op(KIND_RESET + 3'd1, 0), rep);
    send_word(cmd_op(KIND_TOP, 31), rep);
    // accumulative monitor, then one with trigger 0 and the largest recover and latch
    send_word(cmd_register(MODE_ACCUM, 16'd3, 16'd2, 16'd0), rep);
    send_word(cmd_register(MODE_CONT, '0, LEVEL_MAX, LEVEL_MAX), rep);
    send_word(cmd_sample(1, RD_NORMAL), rep);
    repeat (3) send_word(cmd_sample(1, RD_FAULT), rep);
    repeat (2) send_word(cmd_sample(1, RD_NORMAL), rep);
    // trigger 0: any valid reading enters fault
    send_word(cmd_sample(2, RD_NORMAL), rep);
    send_word(cmd_op(KIND_RESET, 2), rep);
    // release of a used slot and of an unused one
    send_word(cmd_op(KIND_RELEASE, 1), rep);
    send_word(cmd_op(KIND_RELEASE, 31), rep);
  endtask

  // fill every slot, register into a full table, free one slot and refill it
  task automatic test_table_full();
    monitor_report_t rep;
    int victim;
    for (int i = 0; i < CHANNELS; i++) send_word(cmd_op(KIND_RELEASE, i), rep);
    for (int i = 0; i < CHANNELS + 2; i++) send_word(random_register(), rep);
    victim = $urandom_range(0, CHANNELS - 1);
    send_word(cmd_op(KIND_RELEASE, victim), rep);
    send_word(random_register(), rep);
    send_word(random_register(), rep);
  endtask

  // back-to-back words that compare counters against the smallest and widest 16-bit levels
  task automatic test_wide_levels();
    monitor_report_t rep;
    int s;
    idle_on = 1'b0;
    for (int i = 0; i < CHANNELS; i++) send_word(cmd_op(KIND_RELEASE, i), rep);
    // trigger 0 and recover 0 flip between fault and normal on every sample
    send_word(cmd_register(MODE_CONT, '0, '0, '0), rep);
    s = rep.slot;
    repeat (24) send_word(cmd_sample(s, RD_FAULT), rep);
    // largest trigger in continuous mode: the fault run never gets there
    send_word(cmd_register(MODE_CONT, LEVEL_MAX, 16'd3, '0), rep);
    s = rep.slot;
    repeat (12) send_word(cmd_sample(s, RD_FAULT), rep);
    repeat (3) send_word(cmd_sample(s, RD_NORMAL), rep);
    // largest trigger and recover in accumulative mode
    send_word(cmd_register(MODE_ACCUM, LEVEL_MAX, LEVEL_MAX, 16'd2), rep);
    s = rep.slot;
    repeat (12) send_word(cmd_sample(s, RD_FAULT), rep);
    send_word(cmd_sample(s, RD_NORMAL), rep);
    send_word(cmd_sample(s, RD_FAULT), rep);
    send_word(cmd_sample(s, RD_NORMAL), rep);
    send_word(cmd_op(KIND_CLEAR, s), rep);
    send_word(cmd_sample(s, RD_NORMAL), rep);
    idle_on = 1'b1;
  endtask

  // mostly register-then-drive episodes, plus interleaved samples and raw noise;
  // only words that touch a live monitor count toward the quota
  task automatic test_random_traffic(input int quota);
    monitor_report_t rep;
    monitor_cmd_t cmd;
    int useful;
    int s;
    int pick;
    int run_left;
    logic [READ_W-1:0] level_now;
    useful = 0;
    while (useful < quota) begin
      // about one stretch in six runs with no gaps or stalls at all
      idle_on = ($urandom_range(0, 5) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        send_word(random_register(), rep);
        if (!rep.ok) begin
          // table full: make room first
          send_word(cmd_op(KIND_RELEASE, $urandom_range(0, CHANNELS - 1)), rep);
          send_word(random_register(), rep);
        end
        s = rep.slot;
        useful++;
        run_left = 0;
        level_now = RD_NORMAL;
        repeat ($urandom_range(4, 30)) begin
          // runs of equal readings so thresholds are actually crossed
          if (run_left == 0) begin
            level_now = ($urandom_range(0, 1) == 1) ? RD_FAULT : RD_NORMAL;
            run_left  = $urandom_range(1, 8);
          end
          run_left--;
          if (mon_locked[s] && $urandom_range(0, 1) == 1) begin
            cmd = cmd_op(KIND_CLEAR, s);
          end else if ($urandom_range(0, 39) == 0) begin
            cmd = cmd_op(KIND_RESET, s);
          end else if ($urandom_range(0, 11) == 0) begin
            cmd = cmd_sample(s, READ_W'($urandom_range(RD_INVALID, RD_SPARE)));
          end else begin
            cmd = cmd_sample(s, level_now);
          end
          send_word(cmd, rep);
          useful++;
        end
      end else if (pick < 17) begin
        // samples spread over the whole table
        repeat ($urandom_range(1, 8)) begin
          s = $urandom_range(0, CHANNELS - 1);
          send_word(cmd_sample(s, READ_W'($urandom_range(RD_NORMAL, RD_FAULT))), rep);
          if (rep.ok) useful++;
        end
      end else begin
        // noise: any kind, any channel, any payload
        repeat ($urandom_range(1, 4)) begin
          send_word(cmd_op(KIND_W'($urandom_range(0, KIND_TOP)),
                           $urandom_range(0, CHANNELS - 1)), rep);
          if (rep.ok) useful++;
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin
    rst               = 1'b1;
    req.valid         = 1'b0;
    req.kind          = '0;
    req.channel       = '0;
    req.raw_reading   = '0;
    req.mode          = 1'b0;
    req.trigger_level = '0;
    req.recover_level = '0;
    req.latch_limit   = '0;
    // shadow table matches the block after reset
    for (int i = 0; i < CHANNELS; i++) begin
      mon_used[i]    = 1'b0;
      mon_mode[i]    = MODE_CONT;
      mon_trigger[i] = '0;
      mon_recover[i] = '0;
      mon_latch[i]   = '0;
      restart_monitor(i);
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_table_full();
    test_wide_levels();
    test_random_traffic(720);

    @(negedge clk);
    req.valid <= 1'b0;
    // drain what is still in flight, then wait idle to catch strays
    for (int k = 0; k < 500 && reports_due.size() != 0; k++) @(posedge clk);
    if (reports_due.size() != 0) begin
      errors++;
      $display("%0t: %0d words never arrived, expected slot %0d ok %0d, actual none",
               $time, reports_due.size(), reports_due[0].slot, reports_due[0].ok);
    end
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
src/fdt_pkg.sv
src/fdt_if.sv
src/fdt_ram.sv
src/fault_debounce_table.sv
tb/fault_debounce_table_tb.sv
